>>> rtl/core/pfde_pkg.sv
package pfde_pkg;

  localparam int PanelWidth  = 128;
  localparam int PanelHeight = 64;
  localparam int StoreBytes  = 1024;
  localparam int AddrW       = 10;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_HLINE = 3'd1,
    OP_VLINE = 3'd2,
    OP_CLEAR = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5,
    OP_TAKE  = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    COL_SET = 2'd0,
    COL_CLR = 2'd1,
    COL_INV = 2'd2,
    COL_KEEP = 2'd3
  } color_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_DONE,
    ST_OUT
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the command and set up the run
    logic clr_step;   // write zero at the sweep address
    logic wr;         // write the modified byte, or the supplied byte for a write
    logic adv;        // advance to the next byte of the run
    logic finish;     // update dirty window and build the result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;   // sweep at its last address
    logic run_empty;  // no byte to touch
    logic run_last;   // current byte is the last of the run
  } stat_t;

endpackage

>>> rtl/core/pfde_ram.sv
module pfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/pfde_ctrl.sv
module pfde_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic [2:0]       op_i,
  input  pfde_pkg::stat_t  stat_i,
  output pfde_pkg::cmd_t   cmd_o
);
  import pfde_pkg::*;

  state_e state_q, state_d;
  op_e    op_q;

  // Hold the captured operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) op_q <= op_e'(op_i);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        unique case (op_e'(op_i))
          OP_CLEAR: state_d = ST_CLEAR;
          OP_PIXEL, OP_HLINE, OP_VLINE: state_d = ST_WAIT;
          OP_WRITE: state_d = ST_WR;
          OP_READ: state_d = ST_RD;
          default: state_d = ST_DONE;
        endcase
      end
      // The sweep after reset has no item behind it and returns to idle.
      ST_CLEAR: if (stat_i.clr_last) state_d = (op_q == OP_CLEAR) ? ST_DONE : ST_IDLE;
      ST_WAIT:  state_d = stat_i.run_empty ? ST_DONE : ST_RD;
      ST_RD:    state_d = (op_q == OP_READ) ? ST_DONE : ST_WR;
      ST_WR: begin
        if (op_q == OP_WRITE || stat_i.run_last) state_d = ST_DONE;
        else state_d = ST_RD;
      end
      ST_DONE:  state_d = ST_OUT;
      ST_OUT:   if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_WR: begin
        cmd_o.wr  = 1'b1;
        cmd_o.adv = 1'b1;
      end
      ST_DONE:  cmd_o.finish = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default:  ;
    endcase
  end
endmodule

>>> rtl/core/pfde_datapath.sv
module pfde_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfde_pkg::cmd_t        cmd_i,
  output pfde_pkg::stat_t       stat_o,
  input  logic [2:0]            op_i,
  input  logic signed [7:0]     x_i,
  input  logic signed [7:0]     y_i,
  input  logic [7:0]            len_i,
  input  logic [1:0]            color_i,
  input  logic [9:0]            bidx_i,
  input  logic [7:0]            wdata_i,
  input  logic                  full_i,
  output logic [40:0]           result_o
);
  import pfde_pkg::*;

  op_e          op_q;
  logic [1:0]   color_q;
  logic [7:0]   wdata_q;
  logic         full_q;
  logic [7:0]   x_q, y_q;
  logic [8:0]   last_q;     // last column (hline) or row (vline)
  logic         draw_q;     // on-screen and non-empty
  logic [10:0]  addr_q;     // current byte address
  logic [8:0]   row_q;      // current row for vline: the start row, then each page top
  logic [8:0]   col_q;      // current column for hline
  logic [7:0]   mask_q;
  logic [AddrW-1:0] clr_q;
  logic [7:0]   dl_q, dr_q, dt_q, db_q;
  logic [40:0]  res_q, res_d;

  logic [7:0] rdata;
  logic       we;
  logic [AddrW-1:0] waddr;
  logic [7:0] wbyte;

  // Command capture decode.
  logic       onscr;
  logic [8:0] xe, ye, hend, vend;
  assign onscr = !x_i[7] && (9'(x_i) < 9'(PanelWidth)) &&
                 !y_i[7] && (9'(y_i) < 9'(PanelHeight));
  assign xe = 9'({1'b0, x_i});
  assign ye = 9'({1'b0, y_i});
  assign hend = ((xe + 9'(len_i)) > 9'(PanelWidth)) ? 9'(PanelWidth - 1)
                : xe + 9'(len_i) - 9'd1;
  assign vend = ((ye + 9'(len_i)) > 9'(PanelHeight)) ? 9'(PanelHeight - 1)
                : ye + 9'(len_i) - 9'd1;

  // Mask of rows from cur to lst within the page starting at row pg.
  function automatic logic [7:0] vmask(input logic [8:0] cur, input logic [8:0] lst,
                                       input logic [8:0] pg);
    logic [7:0] m;
    m = '0;
    for (int b = 0; b < 8; b++)
      if ((pg + 9'(b)) >= cur && (pg + 9'(b)) <= lst) m[b] = 1'b1;
    return m;
  endfunction

  logic [8:0] pg_next;
  assign pg_next = {row_q[8:3], 3'b000} + 9'd8;

  // Build the result of the finishing command.
  always_comb begin
    res_d = '0;
    unique case (op_q)
      OP_READ: res_d[7:0] = rdata;
      OP_TAKE: begin
        if (full_q)
          res_d[40:8] = {8'(PanelHeight - 1), 8'd0, 8'(PanelWidth - 1), 8'd0, 1'b1};
        else if (dt_q <= db_q && dl_q <= dr_q)
          res_d[40:8] = {db_q, dt_q, dr_q, dl_q, 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      dl_q <= 8'd0;
      dr_q <= 8'(PanelWidth - 1);
      dt_q <= 8'd0;
      db_q <= 8'(PanelHeight - 1);
      draw_q <= 1'b0;
      op_q <= OP_NONE;
      color_q <= '0;
      wdata_q <= '0;
      full_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      col_q   <= '0;
      row_q   <= '0;
      addr_q  <= '0;
      last_q  <= '0;
      mask_q  <= '0;
      res_q   <= '0;
    end else begin
      // Sweep the store after reset or on clear.
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        op_q    <= op_e'(op_i);
        color_q <= color_i;
        wdata_q <= wdata_i;
        full_q  <= full_i;
        x_q     <= x_i;
        y_q     <= y_i;
        col_q   <= xe;
        row_q   <= ye;
        addr_q  <= (op_i == OP_WRITE || op_i == OP_READ) ? {1'b0, bidx_i}
                   : 11'(xe) + 11'(ye[8:3]) * 11'(PanelWidth);
        unique case (op_e'(op_i))
          OP_HLINE: begin
            draw_q <= onscr && len_i != 0;
            last_q <= hend;
            mask_q <= 8'd1 << y_i[2:0];
          end
          OP_VLINE: begin
            draw_q <= onscr && len_i != 0;
            last_q <= vend;
            mask_q <= vmask(ye, vend, {ye[8:3], 3'b000});
          end
          default: begin
            draw_q <= onscr && op_i == OP_PIXEL;
            last_q <= (op_i == OP_PIXEL) ? xe : 9'd0;
            mask_q <= 8'd1 << y_i[2:0];
          end
        endcase
      end
      // Step to the next byte of a run.
      if (cmd_i.adv) begin
        if (op_q == OP_VLINE) begin
          row_q  <= pg_next;
          addr_q <= addr_q + 11'(PanelWidth);
          mask_q <= vmask(pg_next, last_q, pg_next);
        end else begin
          col_q  <= col_q + 9'd1;
          addr_q <= addr_q + 11'd1;
        end
      end
      if (cmd_i.finish) begin
        res_q <= res_d;
        unique case (op_q)
          OP_CLEAR, OP_WRITE: begin
            dl_q <= 8'd0; dr_q <= 8'(PanelWidth - 1);
            dt_q <= 8'd0; db_q <= 8'(PanelHeight - 1);
          end
          OP_PIXEL, OP_HLINE, OP_VLINE: if (draw_q) begin
            if (dl_q > x_q) dl_q <= x_q;
            if (dt_q > y_q) dt_q <= y_q;
            if (op_q == OP_VLINE) begin
              if (dr_q < x_q) dr_q <= x_q;
              if (9'(db_q) < last_q) db_q <= last_q[7:0];
            end else begin
              if (9'(dr_q) < last_q) dr_q <= last_q[7:0];
              if (db_q < y_q) db_q <= y_q;
            end
          end
          OP_TAKE: begin
            dl_q <= 8'hFF; dt_q <= 8'hFF; dr_q <= 8'd0; db_q <= 8'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // Modify the byte read from the store, or replace it with the written byte.
  always_comb begin
    wbyte = rdata;
    if (op_q == OP_WRITE) wbyte = wdata_q;
    else begin
      unique case (color_e'(color_q))
        COL_SET:  wbyte = rdata | mask_q;
        COL_CLR:  wbyte = rdata & ~mask_q;
        COL_INV:  wbyte = rdata ^ mask_q;
        COL_KEEP: wbyte = rdata;
      endcase
    end
  end

  assign we    = cmd_i.clr_step || (cmd_i.wr && !addr_q[10]);
  assign waddr = cmd_i.clr_step ? clr_q : addr_q[AddrW-1:0];

  pfde_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.clr_step ? 8'd0 : wbyte),
    .raddr_i (addr_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign stat_o.clr_last  = (clr_q == AddrW'(StoreBytes - 1));
  assign stat_o.run_empty = !draw_q;
  assign stat_o.run_last  = (op_q == OP_VLINE) ? (pg_next > last_q)
                            : (col_q >= last_q);
  assign result_o = res_q;
endmodule

>>> rtl/core/paged_framebuffer_draw_engine.sv
// Per item: take dirty only builds the result, write stores the given byte, read
// fetches it, pixel and hline/vline spend a store read and a write on each byte
// touched (up to 128 and 8 bytes), off-screen draw touches none, clear sweeps all.
// One item at a time: the next item is taken the cycle after the result leaves.
// Reset: async active low; dirty window to full screen, then a clearing pass
// that zeroes the store, during which no item is accepted.
module paged_framebuffer_draw_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0]
  input  logic [2:0]  s_axis_tuser,
  // x_pos[7:0] y_pos[15:8] run_length[23:16] color[25:24]
  // byte_index[35:26] wr_byte[43:36] full_refresh[44], zero fill to 47
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rd_byte[7:0] window_valid[8] window_left[16:9] window_right[24:17]
  // window_top[32:25] window_bottom[40:33], zero fill to 47
  output logic [47:0] m_axis_tdata
);
  import pfde_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [40:0] res;

  pfde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .op_i        (s_axis_tuser),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pfde_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .op_i     (s_axis_tuser),
    .x_i      (s_axis_tdata[7:0]),
    .y_i      (s_axis_tdata[15:8]),
    .len_i    (s_axis_tdata[23:16]),
    .color_i  (s_axis_tdata[25:24]),
    .bidx_i   (s_axis_tdata[35:26]),
    .wdata_i  (s_axis_tdata[43:36]),
    .full_i   (s_axis_tdata[44]),
    .result_o (res)
  );

  // Pad the result to whole bytes.
  assign m_axis_tdata = {7'd0, res};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clr_step, cmd.wr, cmd.finish}))
    else $error("conflicting commands");
`endif
endmodule
